// ===== sv/sgp_pkg.sv =====
// Package for the stepper gauge positioner: sizes, register map, command codes
// and the full-step coil table. No dependencies.
package sgp_pkg;

	localparam int POSITION_BITS = 16;
	localparam int READING_BITS  = 12;

	localparam int RATIO_BITS = 24;
	localparam int FRAC_BITS  = 16;
	localparam logic [RATIO_BITS-1:0] RATIO_RESET = 24'd182409;

	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;
	localparam logic [0:0] REG_IDX_RATIO = 1'b0;

	typedef enum logic {
		CMD_TICK       = 1'b0,
		CMD_SET_TARGET = 1'b1
	} cmd_t;

	// Two-phase full-step sequence
	function automatic logic [3:0] coil_lookup(input logic [1:0] phase);
		logic [3:0] pat;
		case (phase)
			2'd0:    pat = 4'b1100;
			2'd1:    pat = 4'b0110;
			2'd2:    pat = 4'b0011;
			default: pat = 4'b1001;
		endcase
		return pat;
	endfunction

endpackage

// ===== sv/stepper_gauge_positioner_unit.sv =====
// Stepper gauge positioner top level: target scaling, step sequencing, APB ratio register.
// Depends on sgp_pkg.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tuser: cmd; tdata: target_reading
//  m_axis    out  m_axis_tvalid/tready       tdata: coil_pattern..at_target
//  apb       in   psel/penable/pready        paddr, pwdata, pwrite, prdata
//
// One request per cycle unless the output stalls; input register, then result register.
// The 12x24 multiply, saturate and step compare sit between those two registers.
// Position, target and phase update in the cycle the request leaves the input register.
// A stalled output holds both registers; s_axis_tready falls only when both are full.
// arst_n clears valids and state and loads the ratio register with its reset value.
module stepper_gauge_positioner_unit #(
	parameter int POSITION_BITS = sgp_pkg::POSITION_BITS,
	parameter int READING_BITS  = sgp_pkg::READING_BITS,
	localparam int IN_BYTES   = (READING_BITS + 7) / 8,
	localparam int OUT_BYTES  = (POSITION_BITS + 7 + 7) / 8
) (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [8*IN_BYTES-1:0]            s_axis_tdata,  // target_reading
	input  logic                             s_axis_tuser,  // cmd

	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// coil_pattern[3:0], stepped, step_backward, needle_position, at_target, zero pad
	output logic [8*OUT_BYTES-1:0]           m_axis_tdata,

	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sgp_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [sgp_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [sgp_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                             pready
);

	localparam int PROD_BITS = READING_BITS + sgp_pkg::RATIO_BITS;
	localparam int STEP_BITS = PROD_BITS - sgp_pkg::FRAC_BITS;
	localparam int EXT_BITS  = (STEP_BITS > POSITION_BITS) ? STEP_BITS : POSITION_BITS;
	localparam int RES_BITS  = POSITION_BITS + 7;

	// ---------------- configuration ----------------
	logic [sgp_pkg::RATIO_BITS-1:0] ratio_q;
	logic                           reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == sgp_pkg::REG_IDX_RATIO);
	assign prdata  = reg_sel ? sgp_pkg::APB_DATA_BITS'(ratio_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= sgp_pkg::RATIO_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			ratio_q <= pwdata[sgp_pkg::RATIO_BITS-1:0];
		end
	end

	// ---------------- input register ----------------
	logic                     valid_s1;
	sgp_pkg::cmd_t            cmd_s1;
	logic [READING_BITS-1:0]  reading_s1;
	logic                     advance;

	assign advance       = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1     <= sgp_pkg::cmd_t'(s_axis_tuser);
			reading_s1 <= s_axis_tdata[READING_BITS-1:0];
		end
	end

	// ---------------- step logic ----------------
	logic [POSITION_BITS-1:0] position_q, target_q;
	logic [1:0]               phase_q;

	logic [PROD_BITS-1:0]     product;
	logic [EXT_BITS-1:0]      steps_ext;
	logic [EXT_BITS-1:0]      pos_max_ext;
	logic [POSITION_BITS-1:0] target_scaled;
	logic [POSITION_BITS-1:0] position_nx, target_nx;
	logic [1:0]               phase_nx;
	logic                     stepped_nx, backward_nx;

	assign product     = PROD_BITS'(reading_s1) * PROD_BITS'(ratio_q);
	assign steps_ext   = EXT_BITS'(product[PROD_BITS-1:sgp_pkg::FRAC_BITS]);
	assign pos_max_ext = EXT_BITS'({POSITION_BITS{1'b1}});
	assign target_scaled = (steps_ext > pos_max_ext) ? {POSITION_BITS{1'b1}}
	                                                 : steps_ext[POSITION_BITS-1:0];

	always_comb begin
		position_nx = position_q;
		target_nx   = target_q;
		phase_nx    = phase_q;
		stepped_nx  = 1'b0;
		backward_nx = 1'b0;
		case (cmd_s1)
			sgp_pkg::CMD_SET_TARGET: begin
				target_nx = target_scaled;
			end
			default: begin
				if (position_q < target_q) begin
					position_nx = position_q + 1'b1;
					phase_nx    = phase_q + 2'd1;
					stepped_nx  = 1'b1;
				end else if (position_q > target_q) begin
					position_nx = position_q - 1'b1;
					phase_nx    = phase_q - 2'd1;
					stepped_nx  = 1'b1;
					backward_nx = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			target_q   <= '0;
			phase_q    <= '0;
		end else if (advance) begin
			position_q <= position_nx;
			target_q   <= target_nx;
			phase_q    <= phase_nx;
		end
	end

	// ---------------- result register ----------------
	logic [RES_BITS-1:0] result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (!m_axis_tvalid || m_axis_tready) begin
			m_axis_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= {(position_nx == target_nx), position_nx, backward_nx, stepped_nx,
			             sgp_pkg::coil_lookup(phase_nx)};
		end
	end

	assign m_axis_tdata = (8*OUT_BYTES)'(result_q);

endmodule
